// File: rtl/core/search_score_cache_probe_record_macros.svh
// ----------------------------------------------------------------------------
// Search score cache assertion macros
// Shared concurrent assertion forms for the search score cache.
// ----------------------------------------------------------------------------
`ifndef SEARCH_SCORE_CACHE_PROBE_RECORD_MACROS_SVH
`define SEARCH_SCORE_CACHE_PROBE_RECORD_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSCPR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSCPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sscpr_pkg.sv
// ----------------------------------------------------------------------------
// Search score cache package
// Word types, entry layout and codes shared by the search score cache.
// ----------------------------------------------------------------------------
`default_nettype none

package sscpr_pkg;

    // Operation codes carried in the func field.
    localparam logic FUNC_PROBE  = 1'b0;
    localparam logic FUNC_RECORD = 1'b1;

    // Bound kinds held in each slot; empty slots never hit.
    localparam logic [1:0] KIND_EMPTY = 2'd0;
    localparam logic [1:0] KIND_EXACT = 2'd1;
    localparam logic [1:0] KIND_LOWER = 2'd2;
    localparam logic [1:0] KIND_UPPER = 2'd3;

    // Input word: one probe or record command.
    typedef struct packed {
        logic               func;
        logic [63:0]        position_key;
        logic [6:0]         search_depth;
        logic signed [15:0] alpha_bound;
        logic signed [15:0] beta_bound;
        logic signed [15:0] new_score;
        logic [1:0]         bound_kind;
    } t_item;

    // Result word: one per command.
    typedef struct packed {
        logic               hit;
        logic signed [15:0] result_score;
    } t_result;

    // One table slot as stored in memory.
    typedef struct packed {
        logic [63:0]        key;
        logic signed [15:0] score;
        logic [6:0]         depth;
        logic [1:0]         kind;
    } t_entry;

endpackage

`default_nettype wire

// File: rtl/core/search_score_cache_probe_record.sv
// ----------------------------------------------------------------------------
// Search score cache (direct-mapped transposition table)
// Probes and records search results in a direct-mapped table indexed by the
// position key modulo the table size. One command is handled at a time.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                     Word
//  --------  ---------  ----------------------------  ------------------
//  command   in         start high while busy is low  i_item   (t_item)
//  result    out        o_result_valid, one cycle     o_result (t_result)
//
// A command goes from acceptance through the slot index, one memory access
// and, for a probe only, one compare state. When TABLE_ENTRIES is not a
// power of two the slot index comes from a remainder unit that takes
// 8 key bits per cycle. After reset the memory is cleared one slot per
// cycle, every slot in turn, with busy high. The result appears in the
// cycle after the command's last state; the receiver cannot stall it.
// ----------------------------------------------------------------------------
`default_nettype none

module search_score_cache_probe_record #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  sscpr_pkg::t_item     i_item,
    output logic                 o_result_valid,
    output sscpr_pkg::t_result   o_result
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam bit IS_POW2 = ((64'd1 << IDX_W) == 64'(TABLE_ENTRIES));
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [IDX_W:0]   ENTRIES_W = (IDX_W + 1)'(TABLE_ENTRIES);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_MOD    = 5'b00100,
        S_ACCESS = 5'b01000,
        S_CHECK  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    sscpr_pkg::t_item   r_item;
    sscpr_pkg::t_entry  r_rd_data;
    sscpr_pkg::t_result n_result;
    logic               n_result_valid;

    logic [IDX_W-1:0] r_clr_addr, n_clr_addr;
    logic [IDX_W-1:0] r_rem, n_rem;
    logic [2:0]       r_cnt, n_cnt;

    logic [7:0]        key_chunk;
    logic [IDX_W:0]    rem_step;
    logic [IDX_W-1:0]  slot_idx;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_addr;
    sscpr_pkg::t_entry mem_wdata;
    logic              accept;
    logic              tag_match;

    sscpr_pkg::t_entry mem [TABLE_ENTRIES];

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // Remainder unit: eight restoring steps over one key byte, MSB first.
    assign key_chunk = r_item.position_key[{~r_cnt, 3'b000} +: 8];

    always_comb begin
        rem_step = {1'b0, r_rem};
        for (int k = 7; k >= 0; k--) begin
            rem_step = {rem_step[IDX_W-1:0], key_chunk[k]};
            if (rem_step >= ENTRIES_W) begin
                rem_step = rem_step - ENTRIES_W;
            end
        end
    end

    // Slot index is the low key bits for a power-of-two table.
    assign slot_idx = IS_POW2 ? r_item.position_key[IDX_W-1:0] : r_rem;

    // Memory port control: clearing pass or record write.
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = slot_idx;
        mem_wdata = '0;
        if (r_state == S_CLEAR) begin
            mem_we   = 1'b1;
            mem_addr = r_clr_addr;
        end else if (r_state == S_ACCESS && r_item.func == sscpr_pkg::FUNC_RECORD) begin
            mem_we          = 1'b1;
            mem_wdata.key   = r_item.position_key;
            mem_wdata.score = r_item.new_score;
            mem_wdata.depth = r_item.search_depth;
            mem_wdata.kind  = r_item.bound_kind;
        end
    end

    // Single-port table memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        r_rd_data <= mem[mem_addr];
    end

    // Hit decision on the slot read in the access cycle.
    assign tag_match = (r_rd_data.key == r_item.position_key) &&
                       (r_rd_data.kind != sscpr_pkg::KIND_EMPTY) &&
                       (r_rd_data.depth >= r_item.search_depth);

    // Sequencer.
    always_comb begin
        n_state        = r_state;
        n_clr_addr     = r_clr_addr;
        n_rem          = r_rem;
        n_cnt          = r_cnt;
        n_result_valid = 1'b0;
        n_result       = '0;
        unique case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = IS_POW2 ? S_ACCESS : S_MOD;
                end
            end
            S_MOD: begin
                n_rem = rem_step[IDX_W-1:0];
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 3'd7) begin
                    n_state = S_ACCESS;
                end
            end
            S_ACCESS: begin
                if (r_item.func == sscpr_pkg::FUNC_RECORD) begin
                    n_result_valid = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_result_valid = 1'b1;
                if (tag_match) begin
                    case (r_rd_data.kind)
                        sscpr_pkg::KIND_EXACT: begin
                            n_result.hit          = 1'b1;
                            n_result.result_score = r_rd_data.score;
                        end
                        sscpr_pkg::KIND_LOWER: begin
                            if (r_rd_data.score <= r_item.alpha_bound) begin
                                n_result.hit          = 1'b1;
                                n_result.result_score = r_item.alpha_bound;
                            end
                        end
                        sscpr_pkg::KIND_UPPER: begin
                            if (r_rd_data.score >= r_item.beta_bound) begin
                                n_result.hit          = 1'b1;
                                n_result.result_score = r_item.beta_bound;
                            end
                        end
                        default: begin
                            n_result = '0;
                        end
                    endcase
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr_addr     <= '0;
            o_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_clr_addr     <= n_clr_addr;
            o_result_valid <= n_result_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        o_result <= n_result;
    end

`include "search_score_cache_probe_record_macros.svh"

    `SSCPR_ASSERT_NEXT(a_check_gives_result, i_clk, i_rst_n, r_state == S_CHECK,
        o_result_valid, "probe compare cycle did not produce a result")
    `SSCPR_ASSERT_NOW(a_miss_zero_score, i_clk, i_rst_n, o_result_valid && !o_result.hit,
        o_result.result_score == 16'sd0, "missed probe or record returned a nonzero score")
    `SSCPR_ASSERT_NOW(a_record_never_hits, i_clk, i_rst_n, o_result_valid && o_result.hit,
        $past(r_item.func) == sscpr_pkg::FUNC_PROBE, "record command reported a hit")
    `SSCPR_ASSERT_NEXT(a_clear_ends, i_clk, i_rst_n,
        r_state == S_CLEAR && r_clr_addr == LAST_IDX,
        r_state == S_IDLE, "clearing pass did not end at the last slot")
    `SSCPR_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept,
        busy && !o_result_valid, "accepted command did not hold busy")

endmodule

`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// Search score cache testbench
// Sends probe and record words to the direct-mapped score cache and checks
// every result word against a local model of the table. A short table of
// directed words covers the empty slot, depth limits, each bound kind and
// the field extremes. Random words then follow, drawn mostly from a small
// pool of keys, some of which share a slot, so that probes hit, miss and
// alias. Random gaps sit between words.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_ENTRIES = 4096;
    localparam int RANDOM_WORDS  = 1550;
    localparam int KEY_POOL      = 32;
    localparam int MAX_REPORTS   = 10;
    localparam int LIMIT_CYCLES  = 400000;

    // One row of the directed table; a pinned row carries its own result.
    typedef struct {
        sscpr_pkg::t_item   word;
        bit                 pinned;
        sscpr_pkg::t_result reply;
    } t_dir_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    sscpr_pkg::t_item   i_item = '0;
    logic               busy;
    logic               o_result_valid;
    sscpr_pkg::t_result o_result;

    // Pinned result that travels with the word being offered.
    logic               pin_on = 1'b0;
    sscpr_pkg::t_result pin_val = '0;

    // Local copy of the table contents.
    bit [63:0]        cache_key   [TABLE_ENTRIES];
    bit signed [15:0] cache_score [TABLE_ENTRIES];
    bit [6:0]         cache_depth [TABLE_ENTRIES];
    bit [1:0]         cache_kind  [TABLE_ENTRIES];

    sscpr_pkg::t_result pending_replies[$];
    t_dir_row           dir_rows[$];
    bit [63:0]          key_pool [KEY_POOL];

    int n_mismatch = 0;
    int n_records  = 0;
    int n_probes   = 0;
    int n_hits     = 0;

    search_score_cache_probe_record #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Applies one word to the local table and returns the result it gives.
    function automatic sscpr_pkg::t_result probe_or_record(input sscpr_pkg::t_item w);
        sscpr_pkg::t_result r;
        int                 slot;
        bit signed [15:0]   s;
        r = '0;
        slot = int'(w.position_key % TABLE_ENTRIES);
        if (w.func == sscpr_pkg::FUNC_RECORD) begin
            cache_key[slot]   = w.position_key;
            cache_score[slot] = w.new_score;
            cache_depth[slot] = w.search_depth;
            cache_kind[slot]  = w.bound_kind;
        end else if (cache_key[slot] == w.position_key &&
                     cache_kind[slot] != sscpr_pkg::KIND_EMPTY &&
                     cache_depth[slot] >= w.search_depth) begin
            s = cache_score[slot];
            if (cache_kind[slot] == sscpr_pkg::KIND_EXACT) begin
                r.hit = 1'b1;
                r.result_score = s;
            end else if (cache_kind[slot] == sscpr_pkg::KIND_LOWER &&
                         s <= $signed(w.alpha_bound)) begin
                r.hit = 1'b1;
                r.result_score = w.alpha_bound;
            end else if (cache_kind[slot] == sscpr_pkg::KIND_UPPER &&
                         s >= $signed(w.beta_bound)) begin
                r.hit = 1'b1;
                r.result_score = w.beta_bound;
            end
        end
        return r;
    endfunction

    function automatic t_dir_row row(input logic f, input logic [63:0] k, input int d,
                                     input int a, input int b, input int s,
                                     input logic [1:0] kd, input int pin,
                                     input int h, input int res);
        t_dir_row x;
        x.word.func         = f;
        x.word.position_key = k;
        x.word.search_depth = 7'(d);
        x.word.alpha_bound  = 16'(a);
        x.word.beta_bound   = 16'(b);
        x.word.new_score    = 16'(s);
        x.word.bound_kind   = kd;
        x.pinned            = (pin != 0);
        x.reply.hit          = (h != 0);
        x.reply.result_score = 16'(res);
        return x;
    endfunction

    // Mostly pooled keys so that probes find what was recorded earlier.
    function automatic sscpr_pkg::t_item random_word();
        sscpr_pkg::t_item w;
        w.func         = ($urandom_range(0, 99) < 45) ? sscpr_pkg::FUNC_RECORD
                                                      : sscpr_pkg::FUNC_PROBE;
        w.position_key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, KEY_POOL - 1)]
                                                      : {$urandom, $urandom};
        w.search_depth = ($urandom_range(0, 99) < 60) ? 7'($urandom_range(0, 48))
                                                      : 7'($urandom);
        w.alpha_bound  = 16'($urandom);
        w.beta_bound   = 16'($urandom);
        w.new_score    = 16'($urandom);
        w.bound_kind   = ($urandom_range(0, 99) < 5) ? sscpr_pkg::KIND_EMPTY
                                                     : 2'($urandom_range(1, 3));
        return w;
    endfunction

    // Idle cycles before a word: mostly none, sometimes a few, rarely many.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Offers one word and holds it until the block takes it.
    task automatic send_word(input sscpr_pkg::t_item w, input bit pin,
                             input sscpr_pkg::t_result want, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_item  <= w;
        pin_on  <= pin;
        pin_val <= want;
        do @(posedge i_clk); while (busy);
    endtask

    // Lowers start and waits until every pending result has come back.
    task automatic drain_replies();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_replies.size() != 0);
    endtask

    // Check result words first, then record the word taken at this edge.
    always @(posedge i_clk) begin : watch
        sscpr_pkg::t_result want;
        sscpr_pkg::t_result model;
        if (i_rst_n && o_result_valid) begin
            if (pending_replies.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= MAX_REPORTS)
                    $display("[%0t] result word with nothing pending: hit=%0b score=%0d",
                             $realtime, o_result.hit, $signed(o_result.result_score));
            end else begin
                want = pending_replies.pop_front();
                if (o_result.hit !== want.hit ||
                    o_result.result_score !== want.result_score) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS)
                        $display("[%0t] mismatch: hit exp %0b got %0b, score exp %0d got %0d",
                                 $realtime, want.hit, o_result.hit,
                                 $signed(want.result_score), $signed(o_result.result_score));
                end
                if (o_result.hit === 1'b1) n_hits++;
            end
        end
        if (i_rst_n && start && !busy) begin
            model = probe_or_record(i_item);
            pending_replies.push_back(pin_on ? pin_val : model);
            if (i_item.func == sscpr_pkg::FUNC_RECORD) n_records++;
            else n_probes++;
        end
    end

    // Overall time limit for a run that hangs.
    initial begin
        #(LIMIT_CYCLES * 20ns);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        sscpr_pkg::t_result none;
        none = '0;

        // Key pool: odd entries share a slot with the entry before them.
        for (int i = 0; i < KEY_POOL; i++) begin
            key_pool[i] = {$urandom, $urandom};
            if (i % 2 == 1) key_pool[i][11:0] = key_pool[i - 1][11:0];
        end

        // Directed words.
        // Cleared slot with a matching key of zero still misses.
        dir_rows.push_back(row(sscpr_pkg::FUNC_PROBE, 64'h0, 0, 0, 0, 0,
                               sscpr_pkg::KIND_EMPTY, 1, 0, 0));
        dir_rows.push_back(row(sscpr_pkg::FUNC_PROBE, '1, 127, -32768, 32767, 0,
                               sscpr_pkg::KIND_EMPTY, 1, 0, 0));
        // Exact entry at the top key, depth and score.
        dir_rows.push_back(row(sscpr_pkg::FUNC_RECORD, '1, 127, 0, 0, 32767,
                               sscpr_pkg::KIND_EXACT, 1, 0, 0));
        dir_rows.push_back(row(sscpr_pkg::FUNC_PROBE, '1, 127, 0, 0, 0,
                               sscpr_pkg::KIND_EMPTY, 1, 1, 32767));
        dir_rows.push_back(row(sscpr_pkg::FUNC_PROBE, '1, 0, -32768, 32767, -1,
                               sscpr_pkg::KIND_UPPER, 1, 1, 32767));
        // Same slot, different key.
        dir_rows.push_back(row(sscpr_pkg::FUNC_PROBE, 64'hFFF, 0, 0, 0, 0,
                               sscpr_pkg::KIND_EMPTY, 1, 0, 0));
        // Lower bound at the bottom score and depth zero.
        dir_rows.push_back(row(sscpr_pkg::FUNC_RECORD, 64'h123, 0, 5, 5, -32768,
                               sscpr_pkg::KIND_LOWER, 1, 0, 0));
        dir_rows.push_back(row(sscpr_pkg::FUNC_PROBE, 64'h123, 0, -32768, 0, 0,
                               sscpr_pkg::KIND_EMPTY, 1, 1, -32768));
        dir_rows.push_back(row(sscpr_pkg::FUNC_PROBE, 64'h123, 1, 100, 0, 0,
                               sscpr_pkg::KIND_EMPTY, 1, 0, 0));
        dir_rows.push_back(row(sscpr_pkg::FUNC_PROBE, 64'h123, 0, 32767, 0, 0,
                               sscpr_pkg::KIND_EMPTY, 1, 1, 32767));
        // Upper bound: hits only when the score is at or above beta.
        dir_rows.push_back(row(sscpr_pkg::FUNC_RECORD, 64'h8000_0000_0000_0456, 64, 0, 0, 100,
                               sscpr_pkg::KIND_UPPER, 1, 0, 0));
        dir_rows.push_back(row(sscpr_pkg::FUNC_PROBE, 64'h8000_0000_0000_0456, 64, 0, 100, 0,
                               sscpr_pkg::KIND_EMPTY, 1, 1, 100));
        dir_rows.push_back(row(sscpr_pkg::FUNC_PROBE, 64'h8000_0000_0000_0456, 64, 0, 101, 0,
                               sscpr_pkg::KIND_EMPTY, 1, 0, 0));
        dir_rows.push_back(row(sscpr_pkg::FUNC_PROBE, 64'h8000_0000_0000_0456, 65, 0, -32768, 0,
                               sscpr_pkg::KIND_EMPTY, 1, 0, 0));
        dir_rows.push_back(row(sscpr_pkg::FUNC_PROBE, 64'h8000_0000_0000_0456, 3, 0, -32768, 0,
                               sscpr_pkg::KIND_EMPTY, 1, 1, -32768));
        // A record of kind zero leaves the slot reading as empty.
        dir_rows.push_back(row(sscpr_pkg::FUNC_RECORD, 64'h7, 127, 0, 0, 5,
                               sscpr_pkg::KIND_EMPTY, 1, 0, 0));
        dir_rows.push_back(row(sscpr_pkg::FUNC_PROBE, 64'h7, 0, 0, 0, 0,
                               sscpr_pkg::KIND_EMPTY, 1, 0, 0));
        // Overwrite of the same slot by another key.
        dir_rows.push_back(row(sscpr_pkg::FUNC_RECORD, 64'h1007, 10, 0, 0, -1,
                               sscpr_pkg::KIND_EXACT, 0, 0, 0));
        dir_rows.push_back(row(sscpr_pkg::FUNC_PROBE, 64'h7, 0, 0, 0, 0,
                               sscpr_pkg::KIND_EMPTY, 0, 0, 0));
        dir_rows.push_back(row(sscpr_pkg::FUNC_PROBE, 64'h1007, 10, 0, 0, 0,
                               sscpr_pkg::KIND_EMPTY, 0, 0, 0));
        // Lower bound above alpha misses.
        dir_rows.push_back(row(sscpr_pkg::FUNC_RECORD, 64'hA, 20, 0, 0, 0,
                               sscpr_pkg::KIND_LOWER, 0, 0, 0));
        dir_rows.push_back(row(sscpr_pkg::FUNC_PROBE, 64'hA, 5, -1, 0, 0,
                               sscpr_pkg::KIND_EMPTY, 0, 0, 0));
        dir_rows.push_back(row(sscpr_pkg::FUNC_PROBE, 64'hA, 20, 0, 0, 0,
                               sscpr_pkg::KIND_EMPTY, 0, 0, 0));

        // Synchronous reset, then the block clears its table with busy high.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_word(dir_rows[i].word, dir_rows[i].pinned, dir_rows[i].reply, pick_gap());
        drain_replies();

        // Random words; every few hundred words a burst goes without gaps.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 2) drain_replies();
            send_word(random_word(), 1'b0, none, ((n % 300) < 60) ? 0 : pick_gap());
        end

        drain_replies();
        repeat (8) @(posedge i_clk);

        $display("Covered %0d records and %0d probes, %0d probes hit.",
                 n_records, n_probes, n_hits);
        $display("Mismatches seen: %0d.", n_mismatch);
        if (n_mismatch == 0 && pending_replies.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/sscpr_pkg.sv
rtl/core/search_score_cache_probe_record.sv
sim/testbench.sv
